// File: rtl/mer_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_pkg
// shared constants, command codes and control structs of the midpoint
// ellipse rasterizer
// ----------------------------------------------------------------------------
package mer_pkg;

   localparam int AXIS_BITS_DEF  = 10;
   localparam int COORD_BITS_DEF = 12;
   localparam int DEC_BITS       = 48;
   localparam int DELTA_BITS     = 32;

   // item operation codes
   localparam logic OP_START   = 1'b0;
   localparam logic OP_ADVANCE = 1'b1;

   // multiplier operand selection
   localparam logic [3:0] MS_NONE    = 4'd0;
   localparam logic [3:0] MS_AA      = 4'd1;
   localparam logic [3:0] MS_BB      = 4'd2;
   localparam logic [3:0] MS_ASQ_B   = 4'd3;
   localparam logic [3:0] MS_TT      = 4'd4;
   localparam logic [3:0] MS_BSQ_P   = 4'd5;
   localparam logic [3:0] MS_YY      = 4'd6;
   localparam logic [3:0] MS_ASQ_P   = 4'd7;
   localparam logic [3:0] MS_ASQ_BSQ = 4'd8;

   // datapath register actions
   localparam logic [3:0] ACT_NONE     = 4'd0;
   localparam logic [3:0] ACT_LOAD     = 4'd1;
   localparam logic [3:0] ACT_ASQ      = 4'd2;
   localparam logic [3:0] ACT_BSQ      = 4'd3;
   localparam logic [3:0] ACT_INIT     = 4'd4;
   localparam logic [3:0] ACT_ACC_LOAD = 4'd5;
   localparam logic [3:0] ACT_ACC_ADD4 = 4'd6;
   localparam logic [3:0] ACT_ACC_SUB4 = 4'd7;
   localparam logic [3:0] ACT_DEC_DIV  = 4'd8;
   localparam logic [3:0] ACT_R1       = 4'd9;
   localparam logic [3:0] ACT_R2       = 4'd10;

   typedef struct packed {
      logic [3:0] mul_sel;
      logic [3:0] act;
      logic       emit;
   } mer_cmd_type;

   typedef struct packed {
      logic dx_lt_dy;
      logic y_zero;
      logic out_room;
   } mer_status_type;

endpackage

// File: rtl/mer_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_req_if
// request channel: start or advance beats with axes and centre
// ----------------------------------------------------------------------------
interface mer_req_if #(
   parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF,
   parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic                         op;
   logic        [AXIS_BITS-1:0]  semi_axis_a;
   logic        [AXIS_BITS-1:0]  semi_axis_b;
   logic signed [COORD_BITS-1:0] center_x;
   logic signed [COORD_BITS-1:0] center_y;

   modport source (
      output valid, op, semi_axis_a, semi_axis_b, center_x, center_y,
      input  ready
   );
   modport sink (
      input  valid, op, semi_axis_a, semi_axis_b, center_x, center_y,
      output ready
   );
endinterface

// File: rtl/mer_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_rsp_if
// response channel: one beat of four mirrored coordinates per point set
// ----------------------------------------------------------------------------
interface mer_rsp_if #(
   parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
);
   logic                       valid;
   logic                       ready;
   logic signed [COORD_BITS:0] x_right;
   logic signed [COORD_BITS:0] x_left;
   logic signed [COORD_BITS:0] y_top;
   logic signed [COORD_BITS:0] y_bottom;
   logic                       last;

   modport source (
      output valid, x_right, x_left, y_top, y_bottom, last,
      input  ready
   );
   modport sink (
      input  valid, x_right, x_left, y_top, y_bottom, last,
      output ready
   );
endinterface

// File: rtl/mer_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_dp
// datapath: shared multiplier, step arithmetic, decision accumulator and
// output register
// ----------------------------------------------------------------------------
module mer_dp #(
   parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF,
   parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  mer_pkg::mer_cmd_type         cmd,
   output mer_pkg::mer_status_type      status,
   input  logic        [AXIS_BITS-1:0]  semi_axis_a,
   input  logic        [AXIS_BITS-1:0]  semi_axis_b,
   input  logic signed [COORD_BITS-1:0] center_x,
   input  logic signed [COORD_BITS-1:0] center_y,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic signed [COORD_BITS:0]   x_right,
   output logic signed [COORD_BITS:0]   x_left,
   output logic signed [COORD_BITS:0]   y_top,
   output logic signed [COORD_BITS:0]   y_bottom,
   output logic                         last
);

   localparam int SQ_W  = 2 * AXIS_BITS;
   localparam int MUL_W = 2 * AXIS_BITS + 2;
   localparam int OUT_W = COORD_BITS + 1;
   localparam int SUM_W = ((AXIS_BITS > COORD_BITS) ? AXIS_BITS : COORD_BITS) + 2;
   localparam int DEC_W = mer_pkg::DEC_BITS;
   localparam int DLT_W = mer_pkg::DELTA_BITS;

   logic        [AXIS_BITS-1:0]  a_ff, a_in;
   logic        [AXIS_BITS-1:0]  x_ff, x_in;
   logic        [AXIS_BITS-1:0]  y_ff, y_in;
   logic        [SQ_W-1:0]       a_sq_ff, a_sq_in;
   logic        [SQ_W-1:0]       b_sq_ff, b_sq_in;
   logic        [DLT_W-1:0]      dx_ff, dx_in;
   logic        [DLT_W-1:0]      dy_ff, dy_in;
   logic        [DEC_W-1:0]      dec_ff, dec_in;
   logic        [DEC_W-1:0]      acc_ff, acc_in;
   logic        [DEC_W-1:0]      prod_ff, prod_in;
   logic signed [COORD_BITS-1:0] cx_ff, cx_in;
   logic signed [COORD_BITS-1:0] cy_ff, cy_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic        [OUT_W-1:0]      xr_ff, xl_ff, yt_ff, yb_ff;
   logic                         last_ff;

   logic        [MUL_W-1:0]      mul_a, mul_b;
   logic        [2*MUL_W-1:0]    mul_full;
   logic        [AXIS_BITS-1:0]  x_inc, y_dec, y_mag;
   logic        [AXIS_BITS:0]    t_odd;
   logic        [DLT_W-1:0]      dx_step, dy_step;
   logic        [DEC_W-1:0]      acc_adj;
   logic                         dec_neg, dec_pos;
   logic        [SUM_W-1:0]      cx_ext, cy_ext, x_ext, y_ext;

   // shared multiplier operands
   assign t_odd = {x_ff, 1'b1};
   assign y_mag = (y_ff == '0) ? AXIS_BITS'(1) : (y_ff - AXIS_BITS'(1));

   always_comb begin
      case (cmd.mul_sel)
         mer_pkg::MS_AA: begin
            mul_a = MUL_W'(a_ff);
            mul_b = MUL_W'(a_ff);
         end
         mer_pkg::MS_BB: begin
            mul_a = MUL_W'(y_ff);
            mul_b = MUL_W'(y_ff);
         end
         mer_pkg::MS_ASQ_B: begin
            mul_a = MUL_W'(a_sq_ff);
            mul_b = MUL_W'(y_ff);
         end
         mer_pkg::MS_TT: begin
            mul_a = MUL_W'(t_odd);
            mul_b = MUL_W'(t_odd);
         end
         mer_pkg::MS_BSQ_P: begin
            mul_a = MUL_W'(b_sq_ff);
            mul_b = prod_ff[MUL_W-1:0];
         end
         mer_pkg::MS_YY: begin
            mul_a = MUL_W'(y_mag);
            mul_b = MUL_W'(y_mag);
         end
         mer_pkg::MS_ASQ_P: begin
            mul_a = MUL_W'(a_sq_ff);
            mul_b = prod_ff[MUL_W-1:0];
         end
         mer_pkg::MS_ASQ_BSQ: begin
            mul_a = MUL_W'(a_sq_ff);
            mul_b = MUL_W'(b_sq_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_full = mul_a * mul_b;
   assign prod_in  = DEC_W'(mul_full);

   // step arithmetic
   assign x_inc   = (x_ff == '1) ? x_ff : (x_ff + AXIS_BITS'(1));
   assign y_dec   = y_ff - AXIS_BITS'(1);
   assign dx_step = dx_ff + DLT_W'({b_sq_ff, 1'b0});
   assign dy_step = dy_ff - DLT_W'({a_sq_ff, 1'b0});
   assign dec_neg = dec_ff[DEC_W-1];
   assign dec_pos = !dec_ff[DEC_W-1] && (dec_ff != '0);
   assign acc_adj = acc_ff + DEC_W'({acc_ff[DEC_W-1], acc_ff[DEC_W-1]});

   always_comb begin
      a_in    = a_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      a_sq_in = a_sq_ff;
      b_sq_in = b_sq_ff;
      dx_in   = dx_ff;
      dy_in   = dy_ff;
      dec_in  = dec_ff;
      acc_in  = acc_ff;
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      case (cmd.act)
         mer_pkg::ACT_LOAD: begin
            a_in  = semi_axis_a;
            y_in  = semi_axis_b;
            x_in  = '0;
            dx_in = '0;
            cx_in = center_x;
            cy_in = center_y;
         end
         mer_pkg::ACT_ASQ: a_sq_in = prod_ff[SQ_W-1:0];
         mer_pkg::ACT_BSQ: b_sq_in = prod_ff[SQ_W-1:0];
         mer_pkg::ACT_INIT: begin
            dy_in  = DLT_W'({prod_ff, 1'b0});
            dec_in = DEC_W'(b_sq_ff) - prod_ff + DEC_W'(a_sq_ff >> 2);
         end
         mer_pkg::ACT_ACC_LOAD: acc_in = prod_ff;
         mer_pkg::ACT_ACC_ADD4: acc_in = acc_ff + DEC_W'({prod_ff, 2'b00});
         mer_pkg::ACT_ACC_SUB4: acc_in = acc_ff - DEC_W'({prod_ff, 2'b00});
         // quotient by four, rounded toward zero
         mer_pkg::ACT_DEC_DIV: dec_in = {{2{acc_adj[DEC_W-1]}}, acc_adj[DEC_W-1:2]};
         mer_pkg::ACT_R1: begin
            x_in  = x_inc;
            dx_in = dx_step;
            if (dec_neg) begin
               dec_in = dec_ff + DEC_W'(b_sq_ff) + DEC_W'(dx_step);
            end else begin
               y_in   = y_dec;
               dy_in  = dy_step;
               dec_in = dec_ff + DEC_W'(b_sq_ff) + DEC_W'(dx_step) - DEC_W'(dy_step);
            end
         end
         mer_pkg::ACT_R2: begin
            y_in  = y_dec;
            dy_in = dy_step;
            if (dec_pos) begin
               dec_in = dec_ff + DEC_W'(a_sq_ff) - DEC_W'(dy_step);
            end else begin
               x_in   = x_inc;
               dx_in  = dx_step;
               dec_in = dec_ff + DEC_W'(a_sq_ff) - DEC_W'(dy_step) + DEC_W'(dx_step);
            end
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      a_sq_ff <= a_sq_in;
      b_sq_ff <= b_sq_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      dec_ff  <= dec_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
   end

   // mirrored coordinates and output register
   assign cx_ext = {{(SUM_W-COORD_BITS){cx_ff[COORD_BITS-1]}}, cx_ff};
   assign cy_ext = {{(SUM_W-COORD_BITS){cy_ff[COORD_BITS-1]}}, cy_ff};
   assign x_ext  = SUM_W'(x_ff);
   assign y_ext  = SUM_W'(y_ff);

   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         xr_ff   <= OUT_W'(cx_ext + x_ext);
         xl_ff   <= OUT_W'(cx_ext - x_ext);
         yt_ff   <= OUT_W'(cy_ext + y_ext);
         yb_ff   <= OUT_W'(cy_ext - y_ext);
         last_ff <= (y_ff == '0);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign x_right   = xr_ff;
   assign x_left    = xl_ff;
   assign y_top     = yt_ff;
   assign y_bottom  = yb_ff;
   assign last      = last_ff;

   assign status.dx_lt_dy = (dx_ff < dy_ff);
   assign status.y_zero   = (y_ff == '0);
   assign status.out_room = !rsp_valid_ff || rsp_ready;

endmodule

// File: rtl/mer_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_ctrl
// sequencer: start set-up, region steps, region switch and beat hand-off
// ----------------------------------------------------------------------------
module mer_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_op,
   output logic                    req_ready,
   output mer_pkg::mer_cmd_type    cmd,
   input  mer_pkg::mer_status_type status
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SA   = 4'd1;
   localparam logic [3:0] S_SB   = 4'd2;
   localparam logic [3:0] S_SC   = 4'd3;
   localparam logic [3:0] S_SD   = 4'd4;
   localparam logic [3:0] S_R1   = 4'd5;
   localparam logic [3:0] S_W0   = 4'd6;
   localparam logic [3:0] S_W1   = 4'd7;
   localparam logic [3:0] S_W2   = 4'd8;
   localparam logic [3:0] S_W3   = 4'd9;
   localparam logic [3:0] S_W4   = 4'd10;
   localparam logic [3:0] S_W5   = 4'd11;
   localparam logic [3:0] S_W6   = 4'd12;
   localparam logic [3:0] S_R2   = 4'd13;
   localparam logic [3:0] S_EMIT = 4'd14;

   localparam logic [1:0] PH_DONE = 2'd0;
   localparam logic [1:0] PH_R1   = 2'd1;
   localparam logic [1:0] PH_R2   = 2'd2;

   logic [3:0] state_ff, state_in;
   logic [1:0] phase_ff, phase_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      cmd.mul_sel = mer_pkg::MS_NONE;
      cmd.act     = mer_pkg::ACT_NONE;
      cmd.emit    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_op == mer_pkg::OP_START) begin
                  cmd.act  = mer_pkg::ACT_LOAD;
                  phase_in = PH_R1;
                  state_in = S_SA;
               end else begin
                  case (phase_ff)
                     PH_R1: begin
                        if (status.dx_lt_dy) begin
                           state_in = S_R1;
                        end else begin
                           phase_in = PH_R2;
                           state_in = S_W0;
                        end
                     end
                     PH_R2: begin
                        if (status.y_zero) begin
                           phase_in = PH_DONE;
                        end else begin
                           state_in = S_R2;
                        end
                     end
                     default: begin
                        phase_in = PH_DONE;
                     end
                  endcase
               end
            end
         end
         S_SA: begin
            cmd.mul_sel = mer_pkg::MS_AA;
            state_in    = S_SB;
         end
         S_SB: begin
            cmd.mul_sel = mer_pkg::MS_BB;
            cmd.act     = mer_pkg::ACT_ASQ;
            state_in    = S_SC;
         end
         S_SC: begin
            cmd.mul_sel = mer_pkg::MS_ASQ_B;
            cmd.act     = mer_pkg::ACT_BSQ;
            state_in    = S_SD;
         end
         S_SD: begin
            cmd.act  = mer_pkg::ACT_INIT;
            state_in = S_EMIT;
         end
         S_R1: begin
            cmd.act  = mer_pkg::ACT_R1;
            state_in = S_EMIT;
         end
         S_W0: begin
            cmd.mul_sel = mer_pkg::MS_TT;
            state_in    = S_W1;
         end
         S_W1: begin
            cmd.mul_sel = mer_pkg::MS_BSQ_P;
            state_in    = S_W2;
         end
         S_W2: begin
            cmd.mul_sel = mer_pkg::MS_YY;
            cmd.act     = mer_pkg::ACT_ACC_LOAD;
            state_in    = S_W3;
         end
         S_W3: begin
            cmd.mul_sel = mer_pkg::MS_ASQ_P;
            state_in    = S_W4;
         end
         S_W4: begin
            cmd.mul_sel = mer_pkg::MS_ASQ_BSQ;
            cmd.act     = mer_pkg::ACT_ACC_ADD4;
            state_in    = S_W5;
         end
         S_W5: begin
            cmd.act  = mer_pkg::ACT_ACC_SUB4;
            state_in = S_W6;
         end
         S_W6: begin
            cmd.act = mer_pkg::ACT_DEC_DIV;
            if (status.y_zero) begin
               phase_in = PH_DONE;
               state_in = S_IDLE;
            end else begin
               state_in = S_R2;
            end
         end
         S_R2: begin
            cmd.act  = mer_pkg::ACT_R2;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (status.out_room) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
               if (status.y_zero) begin
                  phase_in = PH_DONE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_DONE;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   a_start_setup: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_op == mer_pkg::OP_START)
      |=> (state_ff == S_SA && phase_ff == PH_R1))
      else $error("start beat did not enter set-up in region 1");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && status.y_zero) |=> (phase_ff == PH_DONE))
      else $error("point set with zero y offset did not end the ellipse");

   a_r1_phase: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_R1) |-> (phase_ff == PH_R1))
      else $error("region 1 step outside region 1");

   a_r2_phase: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_R2) |-> (phase_ff == PH_R2 && !status.y_zero))
      else $error("region 2 step outside region 2 or at zero y");

endmodule

// File: rtl/midpoint_ellipse_rasterizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_core
// midpoint ellipse rasterizer with four-way symmetry: start beats set up
// the squares and decision term, advance beats step region 1 or region 2
// ----------------------------------------------------------------------------
// sequence: start runs set-up states SA to SD, region 1 step R1, region 2
//   step R2, region switch W0 to W6 then R2, each then EMIT; the set-up and
//   switch lengths come from the single shared multiplier, one product per cycle
// throughput: one item at a time; an advance with nothing to emit gives no
//   response beat; the next request is taken while a response beat waits
// reset: synchronous, clears the sequencer to idle with no ellipse active
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_core #(
   parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF,
   parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
   input logic         clock,
   input logic         reset,
   mer_req_if.sink     req_chan,
   mer_rsp_if.source   rsp_chan
);

   mer_pkg::mer_cmd_type    cmd;
   mer_pkg::mer_status_type status;
   logic                    req_ready;

   assign req_chan.ready = req_ready;

   mer_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.op),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   mer_dp #(
      .AXIS_BITS  (AXIS_BITS),
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .semi_axis_a (req_chan.semi_axis_a),
      .semi_axis_b (req_chan.semi_axis_b),
      .center_x    (req_chan.center_x),
      .center_y    (req_chan.center_y),
      .rsp_ready   (rsp_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .x_right     (rsp_chan.x_right),
      .x_left      (rsp_chan.x_left),
      .y_top       (rsp_chan.y_top),
      .y_bottom    (rsp_chan.y_bottom),
      .last        (rsp_chan.last)
   );

endmodule
